[sv/rvm_pkg.sv]
// Package for the rotation vector to matrix unit: widths, CORDIC constants,
// atan table. No dependencies.
`timescale 1ns / 1ps
package rvm_pkg;

  localparam int DEF_IN_WIDTH = 16;
  localparam int DEF_OUT_WIDTH = 16;
  localparam int DEF_TRIG_ITERATIONS = 14;

  // Q.30 angle, gain and unity constants
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] INV_GAIN    = 36'sd652032874;
  localparam logic signed [35:0] ONE_Q30     = 36'sd1073741824;

  function automatic logic signed [35:0] atan_lut(input int i);
    logic signed [35:0] r;
    begin
      case (i)
        0: r = 36'sh3243F6A8;  1: r = 36'sh1DAC6705;  2: r = 36'sh0FADBAFC;
        3: r = 36'sh07F56EA6;  4: r = 36'sh03FEAB76;  5: r = 36'sh01FFD55B;
        6: r = 36'sh00FFFAAA;  7: r = 36'sh007FFF55;  8: r = 36'sh003FFFEA;
        9: r = 36'sh001FFFFD;  10: r = 36'sh000FFFFF; 11: r = 36'sh0007FFFF;
        12: r = 36'sh0003FFFF; 13: r = 36'sh0001FFFF; 14: r = 36'sh0000FFFF;
        15: r = 36'sh00007FFF; 16: r = 36'sh00003FFF; 17: r = 36'sh00001FFF;
        18: r = 36'sh00000FFF; 19: r = 36'sh000007FF; 20: r = 36'sh000003FF;
        21: r = 36'sh000001FF; 22: r = 36'sh000000FF; 23: r = 36'sh0000007F;
        24: r = 36'sh0000003F; 25: r = 36'sh0000001F; 26: r = 36'sh0000000F;
        27: r = 36'sh00000008; 28: r = 36'sh00000004; 29: r = 36'sh00000002;
        30: r = 36'sh00000001;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  // Q.30 product: magnitudes, round half away from zero, sign applied after
  function automatic logic signed [35:0] mulq(input logic signed [35:0] a,
                                              input logic signed [35:0] b);
    logic [35:0] ma, mb;
    logic [71:0] p;
    logic [41:0] r;
    begin
      ma = a[35] ? 36'(-a) : 36'(a);
      mb = b[35] ? 36'(-b) : 36'(b);
      p = ma * mb;
      r = 42'((p + (72'(1) << 29)) >> 30);
      return (a[35] != b[35]) ? -$signed(36'(r)) : $signed(36'(r));
    end
  endfunction

endpackage

[sv/rotation_vector_to_matrix_unit.sv]
// Rotation vector to 3x3 rotation matrix by Rodrigues' formula, fully pipelined.
// Depends on rvm_pkg and rvm_sqrt_stage.
`timescale 1ns / 1ps
// One vector is taken every cycle (busy stays low) and its matrix appears
// with done high for one cycle once it has passed these stages: one square of
// lengths stage, one stage per root bit pair, one per quotient bit of the
// axis division (3 lanes), range reduction, one stage per CORDIC
// iteration, and three product/output stages. The receiver cannot stall,
// so there is no back pressure anywhere. A zero vector gives the identity.
module rotation_vector_to_matrix_unit
  import rvm_pkg::*;
#(
  parameter int IN_WIDTH = DEF_IN_WIDTH,
  parameter int OUT_WIDTH = DEF_OUT_WIDTH,
  parameter int TRIG_ITERATIONS = DEF_TRIG_ITERATIONS
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic signed [IN_WIDTH-1:0] rot_x,
  input  logic signed [IN_WIDTH-1:0] rot_y,
  input  logic signed [IN_WIDTH-1:0] rot_z,
  output logic done,
  output logic signed [OUT_WIDTH-1:0] m00, m01, m02,
  output logic signed [OUT_WIDTH-1:0] m10, m11, m12,
  output logic signed [OUT_WIDTH-1:0] m20, m21, m22
);
  localparam int MW = IN_WIDTH;            // magnitude bits
  localparam int SW = 2 * MW + 2;          // squared sum, even
  localparam int RS = SW / 2;              // root stages
  localparam int QB = MW + 31;             // quotient bits covered
  localparam int NW = MW + 31;             // numerator width
  localparam int AW = MW + 19;             // angle bits in Q.30
  localparam int RQ = AW - 32;             // compare/subtract steps for 2*pi
  localparam int LAT = 1 + RS + QB + 1 + TRIG_ITERATIONS + 3;

  assign busy = 1'b0;

  // ---------------- stage A: magnitudes and squared length
  logic [MW-1:0] ma [3];
  logic          sa [3];
  logic [SW-1:0] sq;
  always_ff @(posedge clk) begin
    logic [MW-1:0] t [3];
    for (int i = 0; i < 3; i++) begin
      t[i] = '0;
    end
    t[0] = rot_x[IN_WIDTH-1] ? MW'(-rot_x) : MW'(rot_x);
    t[1] = rot_y[IN_WIDTH-1] ? MW'(-rot_y) : MW'(rot_y);
    t[2] = rot_z[IN_WIDTH-1] ? MW'(-rot_z) : MW'(rot_z);
    for (int i = 0; i < 3; i++) ma[i] <= t[i];
    sa[0] <= rot_x[IN_WIDTH-1];
    sa[1] <= rot_y[IN_WIDTH-1];
    sa[2] <= rot_z[IN_WIDTH-1];
    sq <= SW'(t[0] * t[0]) + SW'(t[1] * t[1]) + SW'(t[2] * t[2]);
  end

  // valid bits
  logic [LAT-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[LAT-2:0], start};
  end

  // ---------------- square root pipeline, magnitudes ride alongside
  logic [SW-1:0] rem [RS+1];
  logic [SW-1:0] rt  [RS+1];
  logic [MW-1:0] sm  [RS+1][3];
  logic          ss  [RS+1][3];
  assign rem[0] = sq;
  assign rt[0] = '0;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sm[0][i] = ma[i];
      ss[0][i] = sa[i];
    end
  end
  for (genvar k = 0; k < RS; k++) begin : g_sqrt
    rvm_sqrt_stage #(.W(SW), .STEP(k)) u_stage (
      .clk(clk), .rem_in(rem[k]), .root_in(rt[k]),
      .rem(rem[k+1]), .root(rt[k+1]));
    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        sm[k+1][i] <= sm[k][i];
        ss[k+1][i] <= ss[k][i];
      end
    end
  end
  logic [MW:0] ang;
  assign ang = (MW+1)'(rt[RS]);

  // ---------------- axis division: restoring, one quotient bit a stage
  logic [NW-1:0] drem [QB+1][3];
  logic [QB-1:0] quo  [QB+1][3];
  logic          dsg  [QB+1][3];
  logic [MW:0]   dang [QB+1];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      drem[0][i] = '0;
      quo[0][i] = '0;
      dsg[0][i] = ss[RS][i];
    end
    dang[0] = ang;
  end
  logic [NW-1:0] num [3];
  always_comb begin
    for (int i = 0; i < 3; i++) num[i] = NW'(sm[RS][i]) << 30;
  end
  logic [NW-1:0] numq [QB+1][3];
  always_comb begin
    for (int i = 0; i < 3; i++) numq[0][i] = num[i];
  end
  for (genvar k = 0; k < QB; k++) begin : g_div
    always_ff @(posedge clk) begin
      logic [NW:0] tr;
      tr = '0;
      for (int i = 0; i < 3; i++) begin
        tr = {drem[k][i], numq[k][i][NW-1]};
        if (tr >= (NW+1)'(dang[k])) begin
          drem[k+1][i] <= NW'(tr - (NW+1)'(dang[k]));
          quo[k+1][i] <= {quo[k][i][QB-2:0], 1'b1};
        end else begin
          drem[k+1][i] <= NW'(tr);
          quo[k+1][i] <= {quo[k][i][QB-2:0], 1'b0};
        end
        numq[k+1][i] <= numq[k][i] << 1;
        dsg[k+1][i] <= dsg[k][i];
      end
      dang[k+1] <= dang[k];
    end
  end

  // ---------------- range reduction
  logic signed [35:0] ua [3];
  logic signed [35:0] rr;
  logic neg_r, zero_r;
  always_ff @(posedge clk) begin
    logic [AW-1:0] a30;
    logic signed [36:0] r;
    logic ng;
    // Q.12 angle to Q.30, then take off multiples of 2*pi from the top down
    a30 = AW'(dang[QB]) << 18;
    for (int j = RQ - 1; j >= 0; j--) begin
      if (a30 >= (AW'(TWO_PI_Q30) << j)) a30 = a30 - (AW'(TWO_PI_Q30) << j);
    end
    r = 37'(a30);
    if (r > 37'(PI_Q30)) r = r - 37'(TWO_PI_Q30);
    ng = 1'b0;
    if (r > 37'(HALF_PI_Q30)) begin
      r = r - 37'(PI_Q30);
      ng = 1'b1;
    end else if (r < -37'(HALF_PI_Q30)) begin
      r = r + 37'(PI_Q30);
      ng = 1'b1;
    end
    rr <= 36'(r);
    neg_r <= ng;
    zero_r <= (dang[QB] == '0);
    for (int i = 0; i < 3; i++) begin
      ua[i] <= dsg[QB][i] ? -$signed(36'(quo[QB][i])) : $signed(36'(quo[QB][i]));
    end
  end

  // ---------------- CORDIC, one iteration a stage
  logic signed [35:0] cx [TRIG_ITERATIONS+1];
  logic signed [35:0] cy [TRIG_ITERATIONS+1];
  logic signed [35:0] cz [TRIG_ITERATIONS+1];
  logic signed [35:0] cu [TRIG_ITERATIONS+1][3];
  logic               cn [TRIG_ITERATIONS+1];
  logic               c0 [TRIG_ITERATIONS+1];
  always_comb begin
    cx[0] = INV_GAIN;
    cy[0] = '0;
    cz[0] = rr;
    cn[0] = neg_r;
    c0[0] = zero_r;
    for (int i = 0; i < 3; i++) cu[0][i] = ua[i];
  end
  for (genvar k = 0; k < TRIG_ITERATIONS; k++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (cz[k] >= 0) begin
        cx[k+1] <= cx[k] - (cy[k] >>> k);
        cy[k+1] <= cy[k] + (cx[k] >>> k);
        cz[k+1] <= cz[k] - atan_lut(k);
      end else begin
        cx[k+1] <= cx[k] + (cy[k] >>> k);
        cy[k+1] <= cy[k] - (cx[k] >>> k);
        cz[k+1] <= cz[k] + atan_lut(k);
      end
      cn[k+1] <= cn[k];
      c0[k+1] <= c0[k];
      for (int i = 0; i < 3; i++) cu[k+1][i] <= cu[k][i];
    end
  end

  // ---------------- products
  localparam int T = TRIG_ITERATIONS;
  logic signed [35:0] cc, sn, omc;
  logic signed [35:0] uu [9];
  logic signed [35:0] su [3];
  logic z1, z2;
  always_ff @(posedge clk) begin
    logic signed [35:0] c;
    c = cn[T] ? -cx[T] : cx[T];
    cc <= c;
    omc <= ONE_Q30 - c;
    sn <= cn[T] ? -cy[T] : cy[T];
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) uu[i*3+j] <= mulq(cu[T][i], cu[T][j]);
    for (int i = 0; i < 3; i++) su[i] <= cu[T][i];
    z1 <= c0[T];
  end
  logic signed [35:0] mt [9];
  always_ff @(posedge clk) begin
    logic signed [35:0] b [9];
    for (int i = 0; i < 9; i++) b[i] = mulq(omc, uu[i]);
    mt[0] <= b[0] + cc;
    mt[4] <= b[4] + cc;
    mt[8] <= b[8] + cc;
    mt[1] <= b[1] - mulq(sn, su[2]);
    mt[2] <= b[2] + mulq(sn, su[1]);
    mt[3] <= b[3] + mulq(sn, su[2]);
    mt[5] <= b[5] - mulq(sn, su[0]);
    mt[6] <= b[6] - mulq(sn, su[1]);
    mt[7] <= b[7] + mulq(sn, su[0]);
    z2 <= z1;
  end

  // ---------------- output rounding, saturation and zero-vector identity
  localparam int SHO = 32 - OUT_WIDTH;
  logic signed [OUT_WIDTH-1:0] mo [9];
  always_ff @(posedge clk) begin
    logic signed [37:0] v;
    logic signed [37:0] lim;
    lim = 38'sd1 <<< (OUT_WIDTH - 2);
    for (int i = 0; i < 9; i++) begin
      v = 38'(mt[i]);
      if (SHO > 0) v = (v + (38'sd1 <<< (SHO - 1))) >>> SHO;
      else v = 38'(mt[i]) <<< (-SHO);
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      if (z2) v = (i % 4 == 0) ? lim : '0;
      mo[i] <= OUT_WIDTH'(v);
    end
  end
  assign done = vld[LAT-1];
  assign {m00, m01, m02, m10, m11, m12, m20, m21, m22} =
    {mo[0], mo[1], mo[2], mo[3], mo[4], mo[5], mo[6], mo[7], mo[8]};
endmodule

[sv/rvm_sqrt_stage.sv]
// One restoring square root step (two radicand bits a stage), registered.
// Depends on rvm_pkg.
`timescale 1ns / 1ps
module rvm_sqrt_stage
  import rvm_pkg::*;
#(
  parameter int W = 40,
  parameter int STEP = 0
) (
  input  logic         clk,
  input  logic [W-1:0] rem_in,
  input  logic [W-1:0] root_in,
  output logic [W-1:0] rem,
  output logic [W-1:0] root
);
  localparam int SH = W - 2 - 2 * STEP;
  logic [W-1:0] bitv, trial;
  always_comb begin
    bitv = W'(1) << SH;
    trial = root_in + bitv;
  end
  always_ff @(posedge clk) begin
    if (rem_in >= trial) begin
      rem <= rem_in - trial;
      root <= (root_in >> 1) + bitv;
    end else begin
      rem <= rem_in;
      root <= root_in >> 1;
    end
  end
endmodule

[verif/rotation_vector_to_matrix_unit_tb.sv]
// Testbench for rotation_vector_to_matrix_unit: drives rotation vectors and
// checks every matrix against an in-bench Rodrigues predictor. Needs rvm_pkg.
`timescale 1ns / 1ps
module rotation_vector_to_matrix_unit_tb;
  import rvm_pkg::*;

  typedef logic [8:0][15:0] matrix_t;

  class matrix_scoreboard;
    matrix_t pending[$];
    int errors;
    longint atan_q30[14] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF};

    function longint unsigned magnitude(longint v);
      return v < 0 ? -v : v;
    endfunction

    function longint prod_q30(longint a, longint b);
      longint unsigned p;
      longint r;
      p = magnitude(a) * magnitude(b);
      r = longint'((p + (64'd1 << 29)) >> 30);
      return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function logic [15:0] entry_q14(longint v);
      longint t;
      t = (v + 32768) >>> 16;
      if (t > 16384) t = 16384;
      if (t < -16384) t = -16384;
      return t[15:0];
    endfunction

    function matrix_t rodrigues_matrix(logic signed [15:0] vx, logic signed [15:0] vy,
                                       logic signed [15:0] vz);
      longint v[3], u[3], m[9];
      longint unsigned len2, root, rem, bitv, q;
      longint r, x, y, dx, dy, c, s, omc;
      bit flip;
      matrix_t res;
      v[0] = vx; v[1] = vy; v[2] = vz;
      len2 = 0;
      for (int i = 0; i < 3; i++) len2 += magnitude(v[i]) * magnitude(v[i]);
      if (len2 == 0) begin
        foreach (res[i]) res[i] = (i % 4 == 0) ? 16'd16384 : 16'd0;
        return res;
      end
      rem = len2; root = 0; bitv = 64'd1 << 62;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
        if (rem >= root + bitv) begin
          rem -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      for (int i = 0; i < 3; i++) begin
        q = (magnitude(v[i]) << 30) / root;
        u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
      // angle reduction to (-pi, pi], then fold into the CORDIC range
      r = longint'((root << 18) % longint'(TWO_PI_Q30));
      flip = 0;
      if (r > longint'(PI_Q30)) r -= longint'(TWO_PI_Q30);
      if (r > longint'(HALF_PI_Q30)) begin
        r -= longint'(PI_Q30); flip = 1;
      end else if (r < -longint'(HALF_PI_Q30)) begin
        r += longint'(PI_Q30); flip = 1;
      end
      x = longint'(INV_GAIN); y = 0;
      for (int i = 0; i < DEF_TRIG_ITERATIONS; i++) begin
        dx = y >>> i; dy = x >>> i;
        if (r >= 0) begin
          x -= dx; y += dy; r -= atan_q30[i];
        end else begin
          x += dx; y -= dy; r += atan_q30[i];
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
      omc = longint'(ONE_Q30) - c;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) m[i*3+j] = prod_q30(omc, prod_q30(u[i], u[j]));
      m[0] += c; m[4] += c; m[8] += c;
      m[1] -= prod_q30(s, u[2]); m[2] += prod_q30(s, u[1]);
      m[3] += prod_q30(s, u[2]); m[5] -= prod_q30(s, u[0]);
      m[6] -= prod_q30(s, u[1]); m[7] += prod_q30(s, u[0]);
      foreach (res[i]) res[i] = entry_q14(m[i]);
      return res;
    endfunction

    function void note_vector(logic signed [15:0] vx, logic signed [15:0] vy,
                              logic signed [15:0] vz);
      pending.push_back(rodrigues_matrix(vx, vy, vz));
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_matrix(matrix_t got);
      matrix_t want;
      if (pending.size() == 0) begin
        report("matrix with no vector outstanding");
        return;
      end
      want = pending.pop_front();
      for (int i = 0; i < 9; i++)
        if (got[i] !== want[i])
          report($sformatf("m%0d%0d got %0d want %0d", i / 3, i % 3,
                           $signed(got[i]), $signed(want[i])));
    endtask
  endclass

  logic clk = 0, rst = 1, start = 0;
  logic busy, done;
  logic signed [15:0] rot_x = 0, rot_y = 0, rot_z = 0;
  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  matrix_scoreboard sb = new();

  always #5 clk = ~clk;

  rotation_vector_to_matrix_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z), .done(done),
    .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
    .m20(m20), .m21(m21), .m22(m22)
  );

  always @(posedge clk) begin
    if (!rst && done) sb.check_matrix({m22, m21, m20, m12, m11, m10, m02, m01, m00});
  end

  // start stays high across back-to-back transfers
  task send_vector(logic signed [15:0] vx, logic signed [15:0] vy, logic signed [15:0] vz);
    int gap;
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5));
    start <= 1; rot_x <= vx; rot_y <= vy; rot_z <= vz;
    do @(posedge clk); while (busy);
    sb.note_vector(vx, vy, vz);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task drain;
    start <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function logic signed [15:0] rand_component();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($signed(16'($urandom_range(0, 1023))) - 512);
      2: return 16'($signed(16'($urandom_range(0, 16383))) - 8192);
      default: return ($urandom_range(0, 4) == 0) ? 16'sd0 : 16'($urandom);
    endcase
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // zero vector, axis extremes, angles near pi/2, pi and 2*pi
    send_vector(0, 0, 0);
    send_vector(32767, 0, 0);
    send_vector(-32768, 0, 0);
    send_vector(0, 32767, 0);
    send_vector(0, -32768, 0);
    send_vector(0, 0, 32767);
    send_vector(0, 0, -32768);
    send_vector(32767, 32767, 32767);
    send_vector(-32768, -32768, -32768);
    send_vector(1, 0, 0);
    send_vector(0, -1, 1);
    send_vector(6434, 0, 0);
    send_vector(12868, 0, 0);
    send_vector(-12868, 0, 0);
    send_vector(0, 12867, 0);
    send_vector(25736, 0, 0);
    send_vector(7430, 7430, 7430);
    send_vector(-16384, 16384, 0);
    drain();
    for (int n = 0; n < 700; n++) begin
      send_vector(rand_component(), rand_component(), rand_component());
      if (n == 350) drain();
    end
    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0) $display("rotation_vector_to_matrix_unit_tb: clean");
    else $display("rotation_vector_to_matrix_unit_tb: errors");
    $finish;
  end

  initial begin
    #2ms;
    $display("rotation_vector_to_matrix_unit_tb: errors");
    $finish;
  end
endmodule
